// ===== src/swmm_pkg.sv =====
// swmm_pkg: shared types, sizes and helpers for the sliding window min/max core
// no dependencies; imported by every module of the core

package swmm_pkg;

	localparam int MAX_WINDOW = 64;
	localparam int SAMPLE_W   = 32;
	localparam int WLEN_W     = 7;
	localparam int SEEN_W     = $clog2(MAX_WINDOW + 1);
	localparam int NUM_CELLS  = MAX_WINDOW - 1;
	localparam int CELL_IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

	// apb register map
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

	// running extremes over the newest samples
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] hi;
		logic signed [SAMPLE_W-1:0] lo;
	} minmax_t;

	// fold one new sample into a min/max pair
	function automatic minmax_t mm_merge(input logic signed [SAMPLE_W-1:0] s,
		input minmax_t m);
		minmax_t r;
		r.lo = (s < m.lo) ? s : m.lo;
		r.hi = (m.hi < s) ? s : m.hi;
		return r;
	endfunction

endpackage

// ===== src/swmm_cell.sv =====
// swmm_cell: one cell of the running min/max chain
// depends on swmm_pkg; cell k holds min/max of the newest k+1 samples

module swmm_cell (
	input  logic                                  clk,
	input  logic                                  shift,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
	input  swmm_pkg::minmax_t                     prev,
	output swmm_pkg::minmax_t                     cur
);
	import swmm_pkg::*;

	minmax_t cur_q;

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (shift) begin
			cur_q <= mm_merge(sample, prev);
		end
	end

	assign cur = cur_q;

endmodule

// ===== src/swmm_tap.sv =====
// swmm_tap: picks the chain cell that matches the window and folds in the new sample
// depends on swmm_pkg; purely combinational, result is registered by the top level

module swmm_tap (
	input  logic [swmm_pkg::WLEN_W-1:0]           window_length,
	input  logic [swmm_pkg::SEEN_W-1:0]           seen_next,
	input  logic signed [swmm_pkg::SAMPLE_W-1:0]  sample,
	input  swmm_pkg::minmax_t                     cells [swmm_pkg::NUM_CELLS],
	output swmm_pkg::minmax_t                     result,
	output logic                                  hit
);
	import swmm_pkg::*;

	logic [SEEN_W-1:0]     win_eff;
	logic [CELL_IDX_W-1:0] sel;
	minmax_t               self_mm;

	// zero acts as one, too long clamps to MAX_WINDOW
	always_comb begin
		if (window_length == '0) begin
			win_eff = SEEN_W'(1);
		end else if (int'(window_length) > MAX_WINDOW) begin
			win_eff = SEEN_W'(MAX_WINDOW);
		end else begin
			win_eff = SEEN_W'(window_length);
		end
	end

	assign sel     = CELL_IDX_W'(win_eff - SEEN_W'(2));
	assign self_mm = '{hi: sample, lo: sample};
	assign hit     = (seen_next >= win_eff);

	always_comb begin
		if (win_eff == SEEN_W'(1)) begin
			result = self_mm;
		end else begin
			result = mm_merge(sample, cells[sel]);
		end
	end

endmodule

// ===== src/sliding_window_min_max_core.sv =====
// sliding_window_min_max_core: streaming min/max over the newest window_length samples
// depends on swmm_pkg, swmm_cell, swmm_tap
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[31:0] sample
// m_*       out  m_tvalid/m_tready  m_tdata[31:0] window_min, [63:32] window_max
// apb       in   psel/penable       paddr 0x0 window_length (7 bits, reset 1)
//
// one word accepted per cycle while s_tready is high, the result is registered and shows in the cycle after its sample
// the chain of MAX_WINDOW-1 cells updates on every accepted word, one compare pair each
// the output register frees s_tready whenever it is empty or being drained
// arst_n clears the sample count and output valid and sets the window register to 1; cell contents stay
// a sample yields a word only once window_length samples (zero as one, capped at MAX_WINDOW) were taken since reset

module sliding_window_min_max_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// apb configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [swmm_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [swmm_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [swmm_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// sample stream in
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [swmm_pkg::SAMPLE_W-1:0]       s_tdata,   // [31:0] sample
	// min/max stream out
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*swmm_pkg::SAMPLE_W-1:0]     m_tdata    // [31:0] window_min, [63:32] window_max
);
	import swmm_pkg::*;

	logic [WLEN_W-1:0]          wlen_q;
	logic [SEEN_W-1:0]          seen_q;
	logic [SEEN_W-1:0]          seen_next;
	logic                       m_valid_q;
	minmax_t                    m_data_q;
	logic                       accept;
	logic                       cfg_wr;
	logic [REG_IDX_W-1:0]       reg_idx;
	logic signed [SAMPLE_W-1:0] sample;
	minmax_t                    cells [NUM_CELLS];
	minmax_t                    result;
	logic                       hit;

	// config port, always ready, single register
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_WINDOW_LENGTH);
	assign prdata  = (reg_idx == REG_WINDOW_LENGTH) ? APB_DATA_W'(wlen_q) : '0;

	// input side stalls only behind a full, stalled output register
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign sample   = $signed(s_tdata);

	// saturating count of samples taken
	assign seen_next = (int'(seen_q) == MAX_WINDOW) ? seen_q : seen_q + SEEN_W'(1);

	// cell k folds the new sample into cell k-1's old pair; cell 0 starts from the sample
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		minmax_t prev;
		if (k == 0) begin : g_head
			assign prev = '{hi: sample, lo: sample};
		end else begin : g_link
			assign prev = cells[k-1];
		end
		swmm_cell u_cell (
			.clk    (clk),
			.shift  (accept),
			.sample (sample),
			.prev   (prev),
			.cur    (cells[k])
		);
	end

	// window pick reads the chain before this word's update
	swmm_tap u_tap (
		.window_length (wlen_q),
		.seen_next     (seen_next),
		.sample        (sample),
		.cells         (cells),
		.result        (result),
		.hit           (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q    <= WLEN_W'(1);
			seen_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				wlen_q <= pwdata[WLEN_W-1:0];
			end
			if (accept) begin
				seen_q    <= seen_next;
				m_valid_q <= hit;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// output word, loaded only with a fresh result
	always_ff @(posedge clk) begin
		if (accept && hit) begin
			m_data_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_data_q.hi, m_data_q.lo};

endmodule

// ===== src/swmm_chk.sv =====
// swmm_chk: port-level assertions for sliding_window_min_max_core
// depends on swmm_pkg; bound to the top level at the end of this file

module swmm_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [swmm_pkg::SAMPLE_W-1:0]       s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [2*swmm_pkg::SAMPLE_W-1:0]     m_tdata
);
	import swmm_pkg::*;

	logic signed [SAMPLE_W-1:0] out_min;
	logic signed [SAMPLE_W-1:0] out_max;

	assign out_min = $signed(m_tdata[SAMPLE_W-1:0]);
	assign out_max = $signed(m_tdata[2*SAMPLE_W-1:SAMPLE_W]);

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// empty output never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// min never above max
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> out_min <= out_max)
		else $error("window min above window max");

	// the newest sample lies inside its own result
	a_cover: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid
			|| (out_min <= $signed($past(s_tdata)) && $signed($past(s_tdata)) <= out_max))
		else $error("result does not cover the newest sample");

	// a new word only follows an accepted sample
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready))
		else $error("output word without an accepted sample");

endmodule

bind sliding_window_min_max_core swmm_chk u_swmm_chk (.*);
